/* hdl/multi_mode_checksum_engine_assert.svh */
// Assertion macros used by the checker file of the checksum engine.
`ifndef MULTI_MODE_CHECKSUM_ENGINE_ASSERT_SVH
`define MULTI_MODE_CHECKSUM_ENGINE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define MMCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define MMCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/mmce_pkg.sv */
// -----------------------------------------------------------------------------
// mmce_pkg
// Types, mode codes and CRC helper functions for the checksum engine.
// -----------------------------------------------------------------------------
package mmce_pkg;

	typedef enum logic [2:0] {
		ALG_XOR     = 3'd0,
		ALG_HASH    = 3'd1,
		ALG_CRC32   = 3'd2,
		ALG_CRC16   = 3'd3,
		ALG_CRC8    = 3'd4,
		ALG_ADLER32 = 3'd5
	} alg_t;

	localparam logic [31:0] CRC32_POLY  = 32'h04C1_1DB7;
	localparam logic [15:0] CRC16_RPOLY = 16'hA001;
	localparam logic [7:0]  CRC8_RPOLY  = 8'h8C;
	localparam logic [16:0] ADLER_MOD   = 17'd65521;

	// Request payload of the input channel.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       last;
	} in_req_t;

	// Accumulator state of one buffer.
	typedef struct packed {
		logic [31:0] running_value;
		logic [15:0] second_sum;
		logic [31:0] word_gather;
		logic [1:0]  byte_position;
		logic        first_word_seen;
	} acc_t;

	// Start state of a buffer for a given mode.
	function automatic acc_t start_acc(logic [2:0] alg);
		acc_t a;
		a = '0;
		if (alg == ALG_CRC16) begin
			a.running_value = 32'h0000_FFFF;
		end else if (alg == ALG_ADLER32) begin
			a.running_value = 32'd1;
		end
		return a;
	endfunction

	function automatic logic [31:0] swap32(logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	// Byte-swapped CRC-32 table entry; a constant table for synthesis.
	function automatic logic [31:0] crc32_entry(logic [7:0] idx);
		logic [31:0] c;
		c = {idx, 24'd0};
		for (int k = 0; k < 8; k++) begin
			c = c[31] ? ((c << 1) ^ CRC32_POLY) : (c << 1);
		end
		return swap32(c);
	endfunction

	function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC16_RPOLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC8_RPOLY) : (c >> 1);
		end
		return c;
	endfunction

	// Modular reduction of a value below twice the modulus.
	function automatic logic [15:0] adler_mod(logic [16:0] v);
		logic [16:0] r;
		r = (v >= ADLER_MOD) ? (v - ADLER_MOD) : v;
		return r[15:0];
	endfunction

endpackage

/* hdl/mmce_stream_if.sv */
// -----------------------------------------------------------------------------
// mmce_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// -----------------------------------------------------------------------------
interface mmce_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* hdl/mmce_acc.sv */
// -----------------------------------------------------------------------------
// mmce_acc
// Next-state logic of the accumulators for one byte request.
// -----------------------------------------------------------------------------
module mmce_acc (
	input  logic [2:0]      alg,
	input  mmce_pkg::acc_t  cur,
	input  logic [7:0]      data_byte,
	output mmce_pkg::acc_t  nxt
);
	import mmce_pkg::*;

	logic [31:0] word;
	logic [31:0] h;
	logic [31:0] c;
	logic [15:0] s1;
	logic [15:0] s2;
	logic [17:0] s1_sum;
	logic [18:0] s2_sum;

	// Byte step for each mode.
	always_comb begin
		nxt    = cur;
		word   = cur.word_gather | ({24'd0, data_byte} << {cur.byte_position, 3'd0});
		h      = '0;
		c      = cur.running_value;
		s1     = cur.running_value[15:0];
		s2     = cur.second_sum;
		s1_sum = '0;
		s2_sum = '0;
		case (alg)
			ALG_HASH: begin
				h = cur.running_value + {{24{data_byte[7]}}, data_byte};
				h = h + (h << 10);
				h = h ^ (h >> 6);
				nxt.running_value = h;
			end
			ALG_CRC16: begin
				if (!cur.byte_position[0]) begin
					nxt.word_gather = {24'd0, data_byte};
				end else begin
					nxt.running_value = {16'd0, crc16_byte(crc16_byte(
						cur.running_value[15:0], cur.word_gather[7:0]), data_byte)};
					nxt.word_gather = '0;
				end
			end
			ALG_CRC8: begin
				nxt.running_value = {24'd0, crc8_byte(cur.running_value[7:0], data_byte)};
			end
			ALG_XOR, ALG_CRC32, ALG_ADLER32: begin
				nxt.word_gather = word;
				if (cur.byte_position == 2'd3) begin
					nxt.word_gather = '0;
					if (alg == ALG_XOR) begin
						nxt.running_value = cur.running_value ^ word;
					end else if (alg == ALG_CRC32) begin
						if (!cur.first_word_seen) begin
							nxt.running_value   = ~word;
							nxt.first_word_seen = 1'b1;
						end else begin
							for (int k = 0; k < 4; k++) begin
								c = crc32_entry(c[7:0]) ^ (c >> 8);
							end
							nxt.running_value = c ^ word;
						end
					end else begin
						// Both Adler sums for a whole word in closed form: s1 gains the
						// four bytes, s2 gains four times the old s1 plus the bytes
						// weighted 4, 3, 2 and 1, reduced by compare-subtracts of four, two and one times the modulus.
						s1_sum = {2'd0, s1} + {10'd0, word[7:0]} + {10'd0, word[15:8]} +
							{10'd0, word[23:16]} + {10'd0, word[31:24]};
						s2_sum = {3'd0, s2} + {1'b0, s1, 2'b00} +
							{9'd0, word[7:0], 2'b00} + {10'd0, word[15:8], 1'b0} +
							{11'd0, word[15:8]} + {10'd0, word[23:16], 1'b0} +
							{11'd0, word[31:24]};
						if (s2_sum >= {ADLER_MOD, 2'b00}) begin
							s2_sum = s2_sum - {ADLER_MOD, 2'b00};
						end
						if (s2_sum >= {1'b0, ADLER_MOD, 1'b0}) begin
							s2_sum = s2_sum - {1'b0, ADLER_MOD, 1'b0};
						end
						nxt.running_value = {16'd0, adler_mod(s1_sum[16:0])};
						nxt.second_sum    = adler_mod(s2_sum[16:0]);
					end
				end
			end
			default: begin
				nxt.running_value = cur.running_value;
			end
		endcase
		nxt.byte_position = cur.byte_position + 2'd1;
	end
endmodule

/* hdl/mmce_finish.sv */
// -----------------------------------------------------------------------------
// mmce_finish
// Final checksum of a buffer from its accumulator state.
// -----------------------------------------------------------------------------
module mmce_finish (
	input  logic [2:0]     alg,
	input  mmce_pkg::acc_t acc,
	output logic [31:0]    checksum
);
	import mmce_pkg::*;

	logic [31:0] h;

	// Mode-specific finishing step.
	always_comb begin
		h = acc.running_value;
		case (alg)
			ALG_XOR:   checksum = acc.running_value ^ acc.word_gather;
			ALG_HASH: begin
				h = h + (h << 3);
				h = h ^ (h >> 11);
				h = h + (h << 15);
				checksum = h;
			end
			ALG_CRC32: checksum = acc.first_word_seen ? ~acc.running_value : '1;
			ALG_CRC16: checksum = {16'd0, acc.running_value[15:0]};
			ALG_CRC8:  checksum = {{24{acc.running_value[7]}}, acc.running_value[7:0]};
			ALG_ADLER32: checksum = {acc.second_sum, acc.running_value[15:0]};
			default:   checksum = '1;
		endcase
	end
endmodule

/* hdl/multi_mode_checksum_engine.sv */
// -----------------------------------------------------------------------------
// multi_mode_checksum_engine
// Byte-stream checksum engine with six selectable algorithms.
// -----------------------------------------------------------------------------
// One byte request is taken every clock cycle unless the output register
// stalls input. Each request is registered in the input register, and the
// accumulators and, for a request with last set, the output register are
// then updated together from it by combinational logic. A full output
// register only stalls input when the result is not taken and a second
// result is due.
// Writing the algorithm register restarts the buffer and must only happen
// while the engine is idle.
module multi_mode_checksum_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_wdata,
	mmce_stream_if.sink       in_ch,
	mmce_stream_if.source     out_ch
);
	import mmce_pkg::*;

	logic [2:0] alg_q;
	acc_t       acc_q;
	acc_t       acc_nxt;
	in_req_t    req_s1;
	logic       vld_s1;
	logic [31:0] sum_nxt;
	logic        adv;

	// Stage 1 advances unless it holds a last request that the full output register cannot take.
	assign adv          = !(vld_s1 && req_s1.last && out_ch.valid && !out_ch.ready);
	assign in_ch.ready  = adv;

	// Algorithm register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q <= ALG_XOR;
		end else if (cfg_we) begin
			alg_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= in_ch.payload;
		end
	end

	mmce_acc u_acc (
		.alg       (alg_q),
		.cur       (acc_q),
		.data_byte (req_s1.data_byte),
		.nxt       (acc_nxt)
	);

	acc_t acc_upd;
	assign acc_upd = req_s1.byte_present ? acc_nxt : acc_q;

	mmce_finish u_finish (
		.alg      (alg_q),
		.acc      (acc_upd),
		.checksum (sum_nxt)
	);

	// Accumulator register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= start_acc(ALG_XOR);
		end else if (cfg_we) begin
			acc_q <= start_acc(cfg_wdata);
		end else if (vld_s1 && adv) begin
			acc_q <= req_s1.last ? start_acc(alg_q) : acc_upd;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (vld_s1 && adv && req_s1.last) begin
			out_ch.valid <= 1'b1;
		end else if (out_ch.ready) begin
			out_ch.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && adv && req_s1.last) begin
			out_ch.payload <= sum_nxt;
		end
	end
endmodule

/* hdl/mmce_checker.sv */
// -----------------------------------------------------------------------------
// mmce_checker
// Port-level checks of the checksum engine, bound to the top level.
// -----------------------------------------------------------------------------
`include "multi_mode_checksum_engine_assert.svh"

module mmce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] checksum
);
	`MMCE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(checksum))
	`MMCE_ASSERT_IMP(a_ready_free, clk, arst_n, !out_valid, in_ready)
	`MMCE_ASSERT_IMP(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready)
endmodule

bind multi_mode_checksum_engine mmce_checker u_mmce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.checksum  (out_ch.payload)
);

/* dv/multi_mode_checksum_engine_test.sv */
// -----------------------------------------------------------------------------
// multi_mode_checksum_engine_test
// Self-checking bench for the byte-stream checksum engine: byte requests are
// driven through every algorithm setting, each checksum is predicted by a
// bit-accurate model inside the bench and compared in arrival order.
// -----------------------------------------------------------------------------
module multi_mode_checksum_engine_test;
	import mmce_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_START = 3000;
	localparam int HOLD_LEN = 400;
	localparam int CALM_START = 1000;
	localparam int CALM_LEN = 800;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_wdata;

	mmce_stream_if #(.payload_t(in_req_t)) in_if ();
	mmce_stream_if #(.payload_t(logic [31:0])) out_if ();

	multi_mode_checksum_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_if.sink),
		.out_ch(out_if.source)
	);

	// Pending requests, expected checksums and bookkeeping.
	in_req_t     pending_bytes[$];
	logic [31:0] expected_sums[$];
	int          errors;
	int          cycle_count;
	int          quiet_cycles;
	int          sums_seen;
	int          bytes_sent;
	int          sums_per_mode[8];
	logic        in_taken;

	// Predictor state.
	logic [2:0]  mode_sel;
	logic [31:0] acc_value;
	logic [15:0] acc_s2;
	logic [31:0] acc_word;
	logic [1:0]  acc_pos;
	logic        acc_first;

	always #2 clk = ~clk;

	function automatic logic [31:0] crc32_step_value(logic [7:0] idx);
		logic [31:0] c;
		c = {idx, 24'd0};
		for (int k = 0; k < 8; k++) begin
			if (c[31]) c = (c << 1) ^ 32'h04C1_1DB7;
			else c = c << 1;
		end
		return {c[7:0], c[15:8], c[23:16], c[31:24]};
	endfunction

	function automatic logic [15:0] modbus_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction

	function automatic logic [7:0] maxim_byte(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
		return c;
	endfunction

	// Clear the accumulators to the start value of the selected mode.
	task automatic restart_buffer();
		acc_value = (mode_sel == ALG_CRC16) ? 32'h0000_FFFF :
			(mode_sel == ALG_ADLER32) ? 32'd1 : 32'd0;
		acc_s2 = '0;
		acc_word = '0;
		acc_pos = '0;
		acc_first = 1'b0;
	endtask

	// Fold a completed little-endian word into the word-based modes.
	task automatic fold_word(logic [31:0] w);
		int unsigned s1;
		int unsigned s2;
		if (mode_sel == ALG_XOR) begin
			acc_value ^= w;
		end else if (mode_sel == ALG_CRC32) begin
			if (!acc_first) begin
				acc_value = ~w;
				acc_first = 1'b1;
			end else begin
				for (int k = 0; k < 4; k++)
					acc_value = crc32_step_value(acc_value[7:0]) ^ (acc_value >> 8);
				acc_value ^= w;
			end
		end else if (mode_sel == ALG_ADLER32) begin
			s1 = acc_value[15:0];
			s2 = acc_s2;
			for (int k = 0; k < 4; k++) begin
				s1 = (s1 + ((w >> (8 * k)) & 8'hFF)) % 65521;
				s2 = (s2 + s1) % 65521;
			end
			acc_value = s1;
			acc_s2 = s2[15:0];
		end
	endtask

	// Work out the effect of one accepted request and any checksum it yields.
	task automatic predict_checksum(in_req_t r);
		logic [31:0] h;
		if (r.byte_present) begin
			if (mode_sel == ALG_HASH) begin
				h = acc_value + {{24{r.data_byte[7]}}, r.data_byte};
				h += h << 10;
				h ^= h >> 6;
				acc_value = h;
			end else if (mode_sel == ALG_CRC16) begin
				if (!acc_pos[0]) begin
					acc_word = {24'd0, r.data_byte};
				end else begin
					acc_value = {16'd0, modbus_byte(acc_value[15:0], acc_word[7:0])};
					acc_value = {16'd0, modbus_byte(acc_value[15:0], r.data_byte)};
					acc_word = '0;
				end
			end else if (mode_sel == ALG_CRC8) begin
				acc_value = {24'd0, maxim_byte(acc_value[7:0], r.data_byte)};
			end else if (mode_sel == ALG_XOR || mode_sel == ALG_CRC32 ||
					mode_sel == ALG_ADLER32) begin
				acc_word |= {24'd0, r.data_byte} << (8 * acc_pos);
				if (acc_pos == 2'd3) begin
					fold_word(acc_word);
					acc_word = '0;
				end
			end
			acc_pos = acc_pos + 2'd1;
		end
		if (r.last) begin
			case (mode_sel)
				ALG_XOR: h = acc_value ^ acc_word;
				ALG_HASH: begin
					h = acc_value;
					h += h << 3;
					h ^= h >> 11;
					h += h << 15;
				end
				ALG_CRC32: h = acc_first ? ~acc_value : 32'hFFFF_FFFF;
				ALG_CRC16: h = {16'd0, acc_value[15:0]};
				ALG_CRC8: h = {{24{acc_value[7]}}, acc_value[7:0]};
				ALG_ADLER32: h = {acc_s2, acc_value[15:0]};
				default: h = 32'hFFFF_FFFF;
			endcase
			expected_sums.push_back(h);
			sums_per_mode[mode_sel]++;
			restart_buffer();
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("ERROR %0t: %s got %08h expected %08h", $realtime, what, got, want);
	endtask

	// Queue one buffer: n bytes with optional bubbles, then its end.
	task automatic queue_buffer(int n, int bubble_pct, bit empty_end);
		in_req_t r;
		for (int i = 0; i < n; i++) begin
			while ($urandom_range(99) < bubble_pct) begin
				r.data_byte = $urandom;
				r.byte_present = 1'b0;
				r.last = 1'b0;
				pending_bytes.push_back(r);
			end
			r.data_byte = $urandom;
			r.byte_present = 1'b1;
			r.last = (i == n - 1) && !empty_end;
			pending_bytes.push_back(r);
		end
		if (empty_end || n == 0) begin
			r.data_byte = $urandom;
			r.byte_present = 1'b0;
			r.last = 1'b1;
			pending_bytes.push_back(r);
		end
	endtask

	task automatic queue_fixed(logic [7:0] b, bit present, bit fin);
		in_req_t r;
		r.data_byte = b;
		r.byte_present = present;
		r.last = fin;
		pending_bytes.push_back(r);
	endtask

	// Change the algorithm once the engine has drained.
	task automatic select_mode(logic [2:0] m);
		wait (pending_bytes.size() == 0 && expected_sums.size() == 0);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_sel = m;
		restart_buffer();
	endtask

	// Driver: a request is held until it has been taken at a rising edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_if.valid && !in_taken) begin
				in_if.valid <= 1'b1;
			end else if (pending_bytes.size() > 0 &&
					((cycle_count >= CALM_START && cycle_count < CALM_START + CALM_LEN) ||
					$urandom_range(99) >= 24)) begin
				in_if.valid <= 1'b1;
				in_if.payload <= pending_bytes[0];
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, one calm window and one long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_LEN)
				out_if.ready <= 1'b0;
			else if (cycle_count >= CALM_START && cycle_count < CALM_START + CALM_LEN)
				out_if.ready <= 1'b1;
			else
				out_if.ready <= ($urandom_range(99) >= 24);
		end
	end

	// Monitor: predict on accepted requests, check accepted checksums.
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			quiet_cycles++;
			in_taken = in_if.valid && in_if.ready;
			if (in_if.valid && in_if.ready) begin
				quiet_cycles = 0;
				bytes_sent++;
				predict_checksum(in_if.payload);
				void'(pending_bytes.pop_front());
			end
			if (out_if.valid && out_if.ready) begin
				quiet_cycles = 0;
				sums_seen++;
				if (expected_sums.size() == 0) begin
					report_mismatch("unexpected checksum", out_if.payload, 32'h0);
				end else begin
					if (out_if.payload !== expected_sums[0])
						report_mismatch("checksum", out_if.payload, expected_sums[0]);
					void'(expected_sums.pop_front());
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR: no progress for %0d cycles", quiet_cycles);
				$display("multi_mode_checksum_engine: mismatch");
				$finish;
			end
		end
	end

	// Stimulus: directed buffers per mode, then random ones.
	initial begin
		logic [2:0] mode_order[$];
		int         len;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_if.valid = 1'b0;
		in_if.payload = '0;
		out_if.ready = 1'b0;
		errors = 0;
		cycle_count = 0;
		quiet_cycles = 0;
		sums_seen = 0;
		bytes_sent = 0;
		in_taken = 1'b0;
		foreach (sums_per_mode[i]) sums_per_mode[i] = 0;
		mode_sel = ALG_XOR;
		restart_buffer();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset mode first, without a register write.
		queue_fixed(8'hFF, 1'b1, 1'b0);
		queue_fixed(8'h80, 1'b1, 1'b0);
		queue_fixed(8'h00, 1'b0, 1'b0);
		queue_fixed(8'h7F, 1'b1, 1'b1);

		mode_order = '{ALG_XOR, ALG_HASH, ALG_CRC32, ALG_CRC16, ALG_CRC8, ALG_ADLER32,
			3'd6, 3'd7, ALG_CRC32, ALG_ADLER32, ALG_CRC16, ALG_XOR, ALG_HASH, ALG_CRC8};
		foreach (mode_order[p]) begin
			select_mode(mode_order[p]);
			if (p < 8) begin
				// Empty buffer, lone byte extremes, tails around a word boundary.
				queue_fixed(8'hA5, 1'b0, 1'b1);
				queue_fixed(8'hFF, 1'b1, 1'b1);
				queue_fixed(8'h00, 1'b1, 1'b1);
				queue_fixed(8'h80, 1'b1, 1'b0);
				queue_fixed(8'h7F, 1'b1, 1'b0);
				queue_fixed(8'h55, 1'b0, 1'b0);
				queue_fixed(8'hFF, 1'b1, 1'b1);
				queue_buffer(4, 0, 1'b0);
				queue_buffer(5, 0, 1'b1);
				queue_buffer(8, 20, 1'b0);
			end
			for (int b = 0; b < 16; b++) begin
				len = ($urandom_range(19) == 0) ? $urandom_range(64, 40) : $urandom_range(12);
				queue_buffer(len, $urandom_range(15), $urandom_range(3) == 0);
			end
		end

		wait (pending_bytes.size() == 0 && expected_sums.size() == 0);
		repeat (10) @(posedge clk);
		$display("Run covered %0d requests and %0d checksums over all eight modes,",
			bytes_sent, sums_seen);
		$display("crc32 %0d, adler32 %0d, invalid codes %0d, with a long output hold-off.",
			sums_per_mode[ALG_CRC32], sums_per_mode[ALG_ADLER32],
			sums_per_mode[6] + sums_per_mode[7]);
		if (errors == 0) begin
			$display("multi_mode_checksum_engine: match");
		end else begin
			$display("multi_mode_checksum_engine: mismatch");
		end
		$finish;
	end

endmodule
